// ===== hw/rtl/sparse_pattern_sorted_insert_assert.svh =====
// Assertion macros for the sparse pattern insert block.
// Included by the top level, which checks its own logic; depends on nothing.
`ifndef SPARSE_PATTERN_SORTED_INSERT_ASSERT_SVH
`define SPARSE_PATTERN_SORTED_INSERT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SPSI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spsi check failed");

// Next-cycle implication, disabled while reset is low.
`define SPSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spsi check failed");

`endif

// ===== hw/rtl/spsi_pkg.sv =====
// Shared constants, operation codes and the cell command type.
// Used by the channel interfaces, the column cells, the chain and the top level.
`default_nettype none

package spsi_pkg;

  localparam int DIM         = 16;
  localparam int STORE_DEPTH = 256;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 4;
  localparam int IDX_W       = 8;
  localparam int CNT_W       = 9;
  localparam int RS_IDX_W    = $clog2(DIM + 1);

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_ROW_READ = 2'd1;
  localparam logic [1:0] OP_COL_READ = 2'd2;
  localparam logic [1:0] OP_CLEAR    = 2'd3;

  // Broadcast to every column cell.
  typedef struct packed {
    logic             ins_req;
    logic [COL_W-1:0] col;
    logic [CNT_W-1:0] start;
    logic [CNT_W-1:0] stop;
    logic [CNT_W-1:0] total;
  } spsi_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spsi_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on spsi_pkg for the field widths.
`default_nettype none

interface spsi_in_if import spsi_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [IDX_W-1:0] entry_index;

  modport source (output valid, operation, row, col, entry_index, input ready);
  modport sink   (input valid, operation, row, col, entry_index, output ready);
endinterface

interface spsi_out_if import spsi_pkg::*;;
  logic             valid;
  logic             ready;
  logic             added;
  logic [CNT_W-1:0] nonzero_count;
  logic [CNT_W-1:0] read_value;

  modport source (output valid, added, nonzero_count, read_value, input ready);
  modport sink   (input valid, added, nonzero_count, read_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sparse_pattern_sorted_insert.sv =====
// Top level of the CSR sparsity pattern builder: control, row starts, result register.
// Depends on spsi_pkg, spsi_if, spsi_col_chain and the assertion macro header.
//
//   channel   dir  handshake          beat fields
//   in_ch     in   valid/ready        operation, row, col, entry_index
//   out_ch    out  valid/ready        added, nonzero_count, read_value
//
// Each item is accepted in ST_IDLE, which latches the beat and the
// clamped bounds of the target row; ST_APPLY then runs the compare and
// shift across the column cell chain and loads the result register.
// Reset (rst_n low, synchronous) clears row starts, the count and the
// handshake state; column cells are not cleared.
// A held result stalls the apply state; no new beat is taken meanwhile.
`default_nettype none
`include "sparse_pattern_sorted_insert_assert.svh"

module sparse_pattern_sorted_insert import spsi_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  spsi_in_if.sink    in_ch,
  spsi_out_if.source out_ch
);

  typedef enum logic {ST_IDLE, ST_APPLY} state_t;

  state_t           state_r;
  logic [1:0]       op_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] start_r;
  logic [CNT_W-1:0] stop_r;
  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] total_nxt;
  logic [CNT_W-1:0] rs_r [DIM+1];

  logic             out_valid_r;
  logic             added_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] rdval_r;

  logic             in_fire;
  logic             go;
  logic             ins_req;
  logic             added_c;
  logic             dup;
  logic [COL_W-1:0] chain_rd;
  logic [CNT_W-1:0] rdval_c;
  logic             row_in_ok;
  logic [CNT_W-1:0] lo_c;
  logic [CNT_W-1:0] hi_c;
  logic [CNT_W-1:0] stop_c;
  logic [CNT_W-1:0] start_c;
  spsi_cmd_t        cmd;

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign in_fire              = in_ch.valid && in_ch.ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.added         = added_r;
  assign out_ch.nonzero_count = count_r;
  assign out_ch.read_value    = rdval_r;

  // Fetch the row's bounds at accept; clamp to the live part of the store.
  assign row_in_ok = in_ch.row < ROW_W'(DIM);
  assign lo_c      = row_in_ok ? rs_r[RS_IDX_W'(in_ch.row)] : '0;
  assign hi_c      = row_in_ok ? rs_r[RS_IDX_W'(in_ch.row) + RS_IDX_W'(1)] : '0;
  assign stop_c    = (hi_c > total_r) ? total_r : hi_c;
  assign start_c   = (lo_c > stop_c) ? stop_c : lo_c;

  // Apply only when the result register is free or being drained.
  assign go      = (state_r == ST_APPLY) && (!out_valid_r || out_ch.ready);
  assign ins_req = go && (op_r == OP_INSERT) && (row_r < ROW_W'(DIM))
                   && ({1'b0, col_r} < (COL_W + 1)'(DIM))
                   && (total_r < CNT_W'(STORE_DEPTH));
  assign added_c = ins_req && !dup;

  always_comb begin
    cmd.ins_req = ins_req;
    cmd.col     = col_r;
    cmd.start   = start_r;
    cmd.stop    = stop_r;
    cmd.total   = total_r;
  end

  spsi_col_chain u_chain (
    .clk    (clk),
    .cmd    (cmd),
    .rd_idx (idx_r),
    .dup    (dup),
    .rd_val (chain_rd)
  );

  always_comb begin
    total_nxt = total_r;
    if (go && (op_r == OP_CLEAR)) begin
      total_nxt = '0;
    end else if (added_c) begin
      total_nxt = total_r + CNT_W'(1);
    end
  end

  always_comb begin
    rdval_c = '0;
    unique case (op_r)
      OP_ROW_READ: begin
        if (row_r <= ROW_W'(DIM)) begin
          rdval_c = rs_r[RS_IDX_W'(row_r)];
        end
      end
      OP_COL_READ: rdval_c = CNT_W'(chain_rd);
      OP_INSERT,
      OP_CLEAR:    rdval_c = '0;
      default:     rdval_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      for (int k = 0; k <= DIM; k++) begin
        rs_r[k] <= '0;
      end
    end else begin
      // Load a new result on apply; otherwise drop the held one once taken.
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            op_r    <= in_ch.operation;
            row_r   <= in_ch.row;
            col_r   <= in_ch.col;
            idx_r   <= in_ch.entry_index;
            start_r <= start_c;
            stop_r  <= stop_c;
            state_r <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (go) begin
            total_r     <= total_nxt;
            added_r     <= added_c;
            count_r     <= total_nxt;
            rdval_r     <= rdval_c;
            state_r     <= ST_IDLE;
            // Advance every later row start on a new nonzero; zero all on clear.
            for (int k = 0; k <= DIM; k++) begin
              if (op_r == OP_CLEAR) begin
                rs_r[k] <= '0;
              end else if (added_c && (ROW_W'(k) > row_r)) begin
                rs_r[k] <= rs_r[k] + CNT_W'(1);
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `SPSI_ASSERT_NEXT(a_accept_to_apply, clk, rst_n, in_fire, state_r == ST_APPLY)
  `SPSI_ASSERT_NOW(a_last_start_is_total, clk, rst_n, 1'b1, rs_r[DIM] == total_r)
  `SPSI_ASSERT_NOW(a_total_in_range, clk, rst_n, 1'b1, total_r <= CNT_W'(STORE_DEPTH))
  `SPSI_ASSERT_NEXT(a_added_bumps_total, clk, rst_n, added_c,
                    total_r == $past(total_r) + CNT_W'(1))
  `SPSI_ASSERT_NEXT(a_apply_loads_result, clk, rst_n, go, out_valid_r)

endmodule

`default_nettype wire

// ===== hw/rtl/spsi_cell.sv =====
// One column-store cell: holds one stored column and decides locally
// whether to keep it, take the new column or take its lower neighbor's value.
`default_nettype none

module spsi_cell import spsi_pkg::*; (
  input  wire logic             clk,
  input  wire spsi_cmd_t        cmd,
  input  wire logic [IDX_W-1:0] pos,
  input  wire logic [COL_W-1:0] prev_v,
  input  wire logic             prev_ge,
  output logic      [COL_W-1:0] v,
  output logic                  ge,
  output logic                  hit
);

  logic [COL_W-1:0] v_r;
  logic [COL_W-1:0] v_nxt;
  logic [CNT_W-1:0] pos_x;

  assign pos_x = {1'b0, pos};
  assign v     = v_r;

  // At or past the insertion point; monotone along the chain.
  assign ge  = (pos_x >= cmd.stop) || ((pos_x >= cmd.start) && (v_r >= cmd.col));
  assign hit = (pos_x >= cmd.start) && (pos_x < cmd.stop) && (v_r == cmd.col);

  always_comb begin
    v_nxt = v_r;
    if (cmd.ins_req) begin
      if (ge && !prev_ge) begin
        v_nxt = cmd.col;
      end else if (prev_ge && (pos_x <= cmd.total)) begin
        v_nxt = prev_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spsi_col_chain.sv =====
// Row of STORE_DEPTH column cells with duplicate detection and read select.
// Depends on spsi_pkg and spsi_cell.
`default_nettype none

module spsi_col_chain import spsi_pkg::*; (
  input  wire logic             clk,
  input  wire spsi_cmd_t        cmd,
  input  wire logic [IDX_W-1:0] rd_idx,
  output logic                  dup,
  output logic      [COL_W-1:0] rd_val
);

  logic [COL_W-1:0] vals [STORE_DEPTH];
  logic             ges  [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] hits;
  spsi_cmd_t        cell_cmd;

  assign dup = |hits;

  // Write only when the column is new to the row.
  always_comb begin
    cell_cmd         = cmd;
    cell_cmd.ins_req = cmd.ins_req && !dup;
  end

  assign rd_val = vals[rd_idx];

  for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
    logic [COL_W-1:0] pv;
    logic             pge;
    if (k == 0) begin : g_first
      assign pv  = '0;
      assign pge = 1'b0;
    end else begin : g_rest
      assign pv  = vals[k-1];
      assign pge = ges[k-1];
    end
    spsi_cell u_cell (
      .clk     (clk),
      .cmd     (cell_cmd),
      .pos     (IDX_W'(k)),
      .prev_v  (pv),
      .prev_ge (pge),
      .v       (vals[k]),
      .ge      (ges[k]),
      .hit     (hits[k])
    );
  end

endmodule

`default_nettype wire

// ===== bench/sparse_pattern_sorted_insert_test.sv =====
// Self-checking bench for the CSR sparsity pattern builder (sparse_pattern_sorted_insert).
// Holds a scoreboard class with its own copy of the row starts and the column store.
// Depends on spsi_pkg, the spsi_if channel interfaces and the block's RTL.
`default_nettype none

module sparse_pattern_sorted_insert_test import spsi_pkg::*; ;

  // One input beat and one result beat, at the channel widths.
  typedef struct packed {
    logic [1:0]       operation;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [IDX_W-1:0] entry_index;
  } pattern_item_t;

  typedef struct packed {
    logic             added;
    logic [CNT_W-1:0] nonzero_count;
    logic [CNT_W-1:0] read_value;
  } pattern_result_t;

  // Tracks the pattern as the block should hold it and queues the
  // result that each accepted beat must produce.
  class pattern_scoreboard;
    logic [CNT_W-1:0] row_start [0:DIM];
    logic [COL_W-1:0] col_store [0:STORE_DEPTH-1];
    logic [CNT_W-1:0] total;
    int               filled_mark;  // store positions below this have been written
    int               fail_count;
    pattern_result_t  expected_results [$];

    function new();
      foreach (row_start[k]) row_start[k] = '0;
      foreach (col_store[k]) col_store[k] = '0;
      total       = '0;
      filled_mark = 0;
      fail_count  = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_item(pattern_item_t it);
      pattern_result_t res;
      int              s, e, loc;
      bit              present;
      res = '0;
      case (it.operation)
        OP_INSERT: begin
          if (it.row < DIM && it.col < DIM && total < STORE_DEPTH) begin
            s = row_start[it.row];
            e = row_start[it.row + 1];
            if (e > total) e = total;
            if (s > e) s = e;
            present = 1'b0;
            for (int k = s; k < e; k++)
              if (col_store[k] == it.col) present = 1'b1;
            if (!present) begin
              loc = s;
              while (loc < e && col_store[loc] < it.col) loc++;
              for (int k = total; k > loc; k--) col_store[k] = col_store[k-1];
              col_store[loc] = it.col;
              for (int k = it.row + 1; k <= DIM; k++) row_start[k] = row_start[k] + 1'b1;
              total       = total + 1'b1;
              res.added   = 1'b1;
            end
          end
        end
        OP_ROW_READ: begin
          if (it.row <= DIM) res.read_value = row_start[it.row];
        end
        OP_COL_READ: begin
          res.read_value = CNT_W'(col_store[it.entry_index]);
        end
        default: begin
          foreach (row_start[k]) row_start[k] = '0;
          total = '0;
        end
      endcase
      res.nonzero_count = total;
      if (total > filled_mark) filled_mark = total;
      expected_results.push_back(res);
    endfunction

    function void check_result(logic added, logic [CNT_W-1:0] count, logic [CNT_W-1:0] value);
      pattern_result_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with no expectation waiting: added %0d count %0d value %0d",
               added, count, value);
        fail_count++;
        return;
      end
      want = expected_results.pop_front();
      if (added !== want.added) begin
        $error("added: expected %0d, actual %0d", want.added, added);
        fail_count++;
      end
      if (count !== want.nonzero_count) begin
        $error("nonzero_count: expected %0d, actual %0d", want.nonzero_count, count);
        fail_count++;
      end
      if (value !== want.read_value) begin
        $error("read_value: expected %0d, actual %0d", want.read_value, value);
        fail_count++;
      end
    endfunction
  endclass

  localparam int HANDSHAKE_TIMEOUT = 2000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES      = 20;

  logic clk = 1'b0;
  logic rst_n;

  spsi_in_if  in_ch ();
  spsi_out_if out_ch ();

  sparse_pattern_sorted_insert dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pattern_scoreboard sb;

  // Idle pressure of the current phase, in percent of cycles.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int unsigned quiet_cycles;

  pattern_item_t item;
  int            pair_order [0:DIM*DIM-1];
  int            swap_pos, swap_val;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each accepted beat, then pick the next ready level.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.added, out_ch.nonzero_count, out_ch.read_value);
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a long run of cycles with no beat on either channel is a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANDSHAKE_TIMEOUT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one beat after a random idle stretch and hold it until taken.
  // Valid stays high into the next call, which either keeps it or drops it once.
  task automatic send_item(input pattern_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= it.operation;
    in_ch.row         <= it.row;
    in_ch.col         <= it.col;
    in_ch.entry_index <= it.entry_index;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic send_op(input logic [1:0] op, input int row, input int col, input int idx);
    pattern_item_t it;
    it.operation   = op;
    it.row         = ROW_W'(row);
    it.col         = COL_W'(col);
    it.entry_index = IDX_W'(idx);
    send_item(it);
  endtask

  // Mostly inserts into valid rows so the pattern grows between rare clears;
  // reads of the column store stay below the highest position ever written.
  task automatic send_random_items(input int count);
    pattern_item_t it;
    int            sel;
    repeat (count) begin
      it  = pattern_item_t'($urandom);
      sel = $urandom_range(99);
      if (sel < 2) begin
        it.operation = OP_CLEAR;
      end else if (sel < 57) begin
        it.operation = OP_INSERT;
        it.row = ($urandom_range(99) < 95) ? ROW_W'($urandom_range(DIM - 1))
                                           : ROW_W'($urandom_range(31));
      end else if (sel < 77 || sb.filled_mark == 0) begin
        it.operation = OP_ROW_READ;
        it.row = ($urandom_range(99) < 85) ? ROW_W'($urandom_range(DIM))
                                           : ROW_W'($urandom_range(31));
      end else begin
        it.operation   = OP_COL_READ;
        it.entry_index = IDX_W'($urandom_range(sb.filled_mark - 1));
      end
      send_item(it);
    end
  endtask

  initial begin
    sb = new();
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= OP_INSERT;
    in_ch.row         <= '0;
    in_ch.col         <= '0;
    in_ch.entry_index <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty reads, row-start bounds, inserts at the ends and in the
    // middle of a row, a duplicate, rows past the matrix, stale reads after clear.
    send_op(OP_ROW_READ, 0, 0, 0);
    send_op(OP_ROW_READ, DIM, 0, 0);
    send_op(OP_ROW_READ, DIM + 1, 0, 0);
    send_op(OP_ROW_READ, 31, 15, 255);
    send_op(OP_INSERT, 0, 0, 0);
    send_op(OP_INSERT, DIM - 1, 15, 255);
    send_op(OP_INSERT, 0, 15, 0);
    send_op(OP_INSERT, 0, 7, 0);
    send_op(OP_INSERT, 0, 0, 0);
    send_op(OP_INSERT, DIM - 1, 0, 0);
    send_op(OP_INSERT, 7, 3, 0);
    send_op(OP_INSERT, DIM, 5, 0);
    send_op(OP_INSERT, 31, 15, 0);
    send_op(OP_ROW_READ, 1, 0, 0);
    send_op(OP_ROW_READ, 8, 0, 0);
    send_op(OP_ROW_READ, DIM, 0, 0);
    send_op(OP_COL_READ, 0, 0, 0);
    send_op(OP_COL_READ, 0, 0, 3);
    send_op(OP_COL_READ, 31, 15, 5);
    send_op(OP_CLEAR, 0, 0, 0);
    send_op(OP_ROW_READ, DIM, 0, 0);
    send_op(OP_COL_READ, 0, 0, 2);
    send_op(OP_INSERT, 3, 9, 0);
    send_op(OP_COL_READ, 0, 0, 0);
    send_op(OP_ROW_READ, 4, 0, 0);

    // Random phases: no idling, sender idle, receiver stalling, both.
    send_random_items(230);
    send_idle_pct = 61;
    send_random_items(230);
    send_idle_pct  = 0;
    recv_stall_pct = 61;
    send_random_items(230);
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    send_random_items(120);

    // Fill every row/column pair in shuffled order to reach a full store,
    // then keep going so inserts hit the full case and reads reach high positions.
    foreach (pair_order[k]) pair_order[k] = k;
    for (int k = DIM * DIM - 1; k > 0; k--) begin
      swap_pos            = $urandom_range(k);
      swap_val            = pair_order[k];
      pair_order[k]       = pair_order[swap_pos];
      pair_order[swap_pos] = swap_val;
    end
    foreach (pair_order[k]) begin
      item.operation   = OP_INSERT;
      item.row         = ROW_W'(pair_order[k] / DIM);
      item.col         = COL_W'(pair_order[k] % DIM);
      item.entry_index = IDX_W'($urandom);
      send_item(item);
    end
    send_random_items(60);
    in_ch.valid <= 1'b0;

    // Drain outstanding results, then wait for stray beats.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
